@@ rtl/multicart_outer_bank_registers_top_defines.svh @@
// Assertion macros for the outer bank register block.
`ifndef MULTICART_OUTER_BANK_REGISTERS_TOP_DEFINES_SVH
`define MULTICART_OUTER_BANK_REGISTERS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MOBR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mobr assertion failed");
`define MOBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mobr assertion failed");
`else
`define MOBR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MOBR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/mobr_pkg.sv @@
`timescale 1ns / 1ps

package mobr_pkg;

  typedef enum logic [2:0] {
    VAR_B37  = 3'd0,
    VAR_B44  = 3'd1,
    VAR_B45  = 3'd2,
    VAR_B47  = 3'd3,
    VAR_B49  = 3'd4,
    VAR_B52  = 3'd5,
    VAR_B205 = 3'd6
  } variant_t;

  localparam logic [2:0] VARIANT_LIMIT = 3'd7;

  localparam logic [15:0] EN_DECODE_MASK = 16'hE001;
  localparam logic [15:0] EN_DECODE_ADDR = 16'hA001;
  localparam logic [2:0]  SEL_WINDOW     = 3'b011;

  localparam logic [18:0] PRG_MASK_64K  = 19'h0FFFF;
  localparam logic [18:0] PRG_MASK_128K = 19'h1FFFF;
  localparam logic [18:0] PRG_MASK_256K = 19'h3FFFF;
  localparam logic [18:0] PRG_MASK_512K = 19'h7FFFF;
  localparam logic [17:0] CHR_MASK_128K = 18'h1FFFF;
  localparam logic [17:0] CHR_MASK_256K = 18'h3FFFF;

  typedef struct packed {
    logic [15:0] write_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic        to_core;
    logic [20:0] prg_offset;
    logic [18:0] prg_mask;
    logic [21:0] chr_offset;
    logic [17:0] chr_mask;
    logic        prg_mode_mmc3;
    logic [18:0] prg32_base;
    logic        regs_locked;
  } out_item_t;

  typedef logic [2:0] cfg_item_t;

  typedef struct packed {
    logic [20:0] prg_offset;
    logic [18:0] prg_mask;
    logic [21:0] chr_offset;
    logic [17:0] chr_mask;
    logic        select_enabled;
    logic        select_locked;
    logic [1:0]  sequence_index;
    logic [3:0]  chr_mask_code;
    logic [1:0]  prg32_bank;
    logic        prg_mode;
  } bank_state_t;

  function automatic bank_state_t reset_state(input variant_t v);
    bank_state_t s;
    s = '0;
    case (v)
      VAR_B37: begin
        s.prg_mask = PRG_MASK_64K;
        s.chr_mask = CHR_MASK_128K;
      end
      VAR_B45: begin
        s.prg_mask = PRG_MASK_512K;
        s.chr_mask = CHR_MASK_256K;
      end
      VAR_B52, VAR_B205: begin
        s.prg_mask = PRG_MASK_256K;
        s.chr_mask = CHR_MASK_256K;
      end
      default: begin
        s.prg_mask = PRG_MASK_128K;
        s.chr_mask = CHR_MASK_128K;
      end
    endcase
    return s;
  endfunction

  function automatic logic [17:0] b45_chr_mask(input logic [21:0] chr_off,
                                               input logic [3:0] code);
    logic [3:0]  code_e;
    logic [3:0]  sh;
    logic [8:0]  span;
    logic [18:0] full;
    code_e = (chr_off != '0 || code != '0) ? code : 4'hF;
    sh     = ~code_e;
    span   = {1'b0, 8'hFF >> sh} + 9'd1;
    full   = {span, 10'b0} - 19'd1;
    return full[17:0];
  endfunction

endpackage

@@ rtl/mobr_chan_if.sv @@
`timescale 1ns / 1ps

interface mobr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/mobr_update.sv @@
`timescale 1ns / 1ps

module mobr_update import mobr_pkg::*; (
  input  variant_t    variant,
  input  bank_state_t cur,
  input  in_item_t    item,
  output bank_state_t nxt,
  output logic        to_core
);

  logic        in_sel;
  logic        in_en;
  logic        en_val;
  logic [7:0]  d;
  logic [2:0]  c52;
  logic [19:0] prg_mask45;

  assign d          = item.write_data;
  assign in_sel     = item.write_address[15:13] == SEL_WINDOW;
  assign in_en      = (item.write_address & EN_DECODE_MASK) == EN_DECODE_ADDR;
  assign en_val     = d[7] & ~d[6];
  assign c52        = {d[2], d[5:4]};
  assign prg_mask45 = {7'({1'b0, ~d[5:0]} + 7'd1), 13'b0} - 20'd1;

  always_comb begin
    nxt     = cur;
    to_core = 1'b1;
    case (variant)
      VAR_B37: begin
        if (in_sel) begin
          to_core = 1'b0;
          if (cur.select_enabled) begin
            nxt.chr_mask = CHR_MASK_128K;
            if (d[2:0] < 3'd3) begin
              nxt.prg_offset = '0;
              nxt.prg_mask   = PRG_MASK_64K;
              nxt.chr_offset = '0;
            end else if (d[2:0] == 3'd3) begin
              nxt.prg_offset = 21'h10000;
              nxt.prg_mask   = PRG_MASK_64K;
              nxt.chr_offset = '0;
            end else if (d[2:0] < 3'd7) begin
              nxt.prg_offset = 21'h20000;
              nxt.prg_mask   = PRG_MASK_128K;
              nxt.chr_offset = 22'h20000;
            end else begin
              nxt.prg_offset = 21'h30000;
              nxt.prg_mask   = PRG_MASK_64K;
              nxt.chr_offset = 22'h20000;
            end
          end
        end else if (in_en) begin
          to_core            = 1'b0;
          nxt.select_enabled = en_val;
        end
      end
      VAR_B44: begin
        if (in_en) begin
          to_core = 1'b0;
          if (d[2:0] < 3'd6) begin
            nxt.prg_offset = {1'b0, d[2:0], 17'b0};
            nxt.chr_offset = {2'b0, d[2:0], 17'b0};
            nxt.prg_mask   = PRG_MASK_128K;
            nxt.chr_mask   = CHR_MASK_128K;
          end else begin
            nxt.prg_offset = 21'hC0000;
            nxt.chr_offset = 22'hC0000;
            nxt.prg_mask   = PRG_MASK_256K;
            nxt.chr_mask   = CHR_MASK_256K;
          end
        end
      end
      VAR_B45: begin
        if (in_sel && !cur.select_locked) begin
          to_core            = 1'b0;
          nxt.sequence_index = cur.sequence_index + 2'd1;
          case (cur.sequence_index)
            2'd0: begin
              nxt.chr_offset = {cur.chr_offset[21:18], d, 10'b0};
              nxt.chr_mask   = b45_chr_mask(nxt.chr_offset, cur.chr_mask_code);
            end
            2'd1: begin
              nxt.prg_offset = {d, 13'b0};
            end
            2'd2: begin
              nxt.chr_offset    = {d[7:4], cur.chr_offset[17:0]};
              nxt.chr_mask_code = d[3:0];
              nxt.chr_mask      = b45_chr_mask(nxt.chr_offset, d[3:0]);
            end
            default: begin
              nxt.select_locked = d[6];
              nxt.prg_mask      = prg_mask45[18:0];
            end
          endcase
        end
      end
      VAR_B47, VAR_B49: begin
        if (in_sel) begin
          to_core = 1'b0;
          if (cur.select_enabled) begin
            if (variant == VAR_B47) begin
              nxt.prg_offset = {3'b0, d[0], 17'b0};
              nxt.chr_offset = {4'b0, d[0], 17'b0};
            end else begin
              nxt.prg_offset = {2'b0, d[7:6], 17'b0};
              nxt.chr_offset = {3'b0, d[7:6], 17'b0};
              nxt.prg_mask   = PRG_MASK_128K;
              nxt.chr_mask   = CHR_MASK_128K;
              nxt.prg32_bank = d[5:4];
              nxt.prg_mode   = d[0];
            end
          end
        end else if (in_en) begin
          to_core            = 1'b0;
          nxt.select_enabled = en_val;
        end
      end
      VAR_B52: begin
        if (in_sel && !cur.select_locked) begin
          to_core = 1'b0;
          if (cur.select_enabled) begin
            if (d[3]) begin
              nxt.prg_mask   = PRG_MASK_128K;
              nxt.prg_offset = {1'b0, d[2:0], 17'b0};
            end else begin
              nxt.prg_mask   = PRG_MASK_256K;
              nxt.prg_offset = {1'b0, d[2:1], 18'b0};
            end
            if (d[6]) begin
              nxt.chr_mask   = CHR_MASK_128K;
              nxt.chr_offset = {2'b0, c52, 17'b0};
            end else begin
              nxt.chr_mask   = CHR_MASK_256K;
              nxt.chr_offset = {2'b0, c52[2:1], 18'b0};
            end
            nxt.select_locked = d[7];
          end
        end else if (in_en) begin
          to_core            = 1'b0;
          nxt.select_enabled = en_val;
        end
      end
      VAR_B205: begin
        if (in_sel) begin
          to_core        = 1'b0;
          nxt.prg_offset = {2'b0, d[1:0], 17'b0};
          nxt.chr_offset = {3'b0, d[1:0], 17'b0};
          nxt.prg_mask   = d[1] ? PRG_MASK_128K : PRG_MASK_256K;
          nxt.chr_mask   = d[1] ? CHR_MASK_128K : CHR_MASK_256K;
        end
      end
      default: begin
        nxt     = cur;
        to_core = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/multicart_outer_bank_registers_top.sv @@
`timescale 1ns / 1ps
// Outer bank registers for MMC3 game-select multicarts.
// in_bus carries one CPU write beat (write_address, write_data). out_bus
// returns one beat per write: whether the write passes on to the MMC3 core
// or RAM, and the PRG/CHR offsets and masks, 32 KiB mode and bank base and
// lock flag as they stand after that write.
// cfg_bus writes the board variant (0..6); code 7 is dropped. A variant write
// also returns all bank state to the defaults of the new variant. Write it
// only while no beat is in flight.
// Latency: the result beat is valid the cycle after the write is accepted.
// Throughput: one write per cycle while the receiver takes each beat; the decode
// and state update sit between the state registers and the result register,
// so consecutive writes flow without gaps.
// When the receiver stalls, the result register holds its beat and in_bus
// ready drops until the beat is taken; a beat is accepted in the same cycle
// the held one leaves.
// Reset (rst_n low, synchronous): variant 0 (board 37), default masks, all
// offsets, enables and locks cleared, result register empty.
`include "multicart_outer_bank_registers_top_defines.svh"

module multicart_outer_bank_registers_top import mobr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  mobr_chan_if.sink    in_bus,
  mobr_chan_if.source  out_bus,
  mobr_chan_if.sink    cfg_bus
);

  variant_t    variant_r;
  bank_state_t state_r;
  bank_state_t state_nxt;
  logic        to_core_nxt;
  out_item_t   result_nxt;
  out_item_t   out_data_r;
  logic        out_valid_r;
  logic        in_acc;
  logic        cfg_acc;
  in_item_t    in_item;

  assign in_item       = in_bus.data;
  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign cfg_acc       = cfg_bus.valid && cfg_bus.ready;
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  mobr_update u_update (
    .variant (variant_r),
    .cur     (state_r),
    .item    (in_item),
    .nxt     (state_nxt),
    .to_core (to_core_nxt)
  );

  always_comb begin
    result_nxt.to_core     = to_core_nxt;
    result_nxt.prg_offset  = state_nxt.prg_offset;
    result_nxt.prg_mask    = state_nxt.prg_mask;
    result_nxt.chr_offset  = state_nxt.chr_offset;
    result_nxt.chr_mask    = state_nxt.chr_mask;
    result_nxt.regs_locked = state_nxt.select_locked;
    if (variant_r == VAR_B49) begin
      result_nxt.prg_mode_mmc3 = state_nxt.prg_mode;
      result_nxt.prg32_base    = {2'b0, state_nxt.prg32_bank, 15'b0} |
                                 state_nxt.prg_offset[18:0];
    end else begin
      result_nxt.prg_mode_mmc3 = 1'b1;
      result_nxt.prg32_base    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r   <= VAR_B37;
      state_r     <= reset_state(VAR_B37);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_acc && cfg_bus.data < VARIANT_LIMIT) begin
        variant_r <= variant_t'(cfg_bus.data);
        state_r   <= reset_state(variant_t'(cfg_bus.data));
      end else if (in_acc) begin
        state_r <= state_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= result_nxt;
    end
  end

  `MOBR_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, out_valid_r && !out_bus.ready, !in_bus.ready)
  `MOBR_ASSERT_NEXT(a_accept_gives_beat, clk, rst_n, in_acc, out_valid_r)
  `MOBR_ASSERT_IMP(a_fixed_mode_fields, clk, rst_n, out_valid_r && variant_r != VAR_B49, out_data_r.prg_mode_mmc3 && out_data_r.prg32_base == '0)
  `MOBR_ASSERT_NEXT(a_lock_sticks, clk, rst_n, state_r.select_locked && !cfg_acc, state_r.select_locked)

endmodule

@@ dv/multicart_outer_bank_registers_top_tb.sv @@
`timescale 1ns / 1ps

module multicart_outer_bank_registers_top_tb;
  import mobr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  mobr_chan_if #(.payload_t(in_item_t))  in_ch ();
  mobr_chan_if #(.payload_t(out_item_t)) out_ch ();
  mobr_chan_if #(.payload_t(cfg_item_t)) cfg_ch ();

  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      out_rdy = 1'b0;
  logic      cfg_valid = 1'b0;
  cfg_item_t cfg_data = '0;
  logic      long_hold = 1'b0;

  assign in_ch.valid  = in_valid;
  assign in_ch.data   = in_data;
  assign out_ch.ready = out_rdy;
  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.data  = cfg_data;

  multicart_outer_bank_registers_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch),
    .cfg_bus(cfg_ch)
  );

  in_item_t    pending_writes[$];
  out_item_t   expected_beats[$];
  int unsigned writes_queued = 0;
  int unsigned writes_taken = 0;
  int unsigned failures = 0;

  int unsigned in_gap = 0, in_stretch = 0, out_gap = 0, out_stretch = 0;
  bit          in_calm = 1'b0, out_calm = 1'b0;

  // Bank state mirror
  variant_t    board;
  logic [20:0] prg_off;
  logic [18:0] prg_msk;
  logic [21:0] chr_off;
  logic [17:0] chr_msk;
  logic        sel_en, sel_lock, mode32;
  logic [1:0]  seq_idx, bank32;
  logic [3:0]  chr_code;

  function automatic void clear_bank_state();
    prg_off = '0;
    chr_off = '0;
    sel_en = 1'b0;
    sel_lock = 1'b0;
    seq_idx = '0;
    chr_code = '0;
    bank32 = '0;
    mode32 = 1'b0;
    case (board)
      VAR_B37: begin
        prg_msk = PRG_MASK_64K;
        chr_msk = CHR_MASK_128K;
      end
      VAR_B45: begin
        prg_msk = PRG_MASK_512K;
        chr_msk = CHR_MASK_256K;
      end
      VAR_B52, VAR_B205: begin
        prg_msk = PRG_MASK_256K;
        chr_msk = CHR_MASK_256K;
      end
      default: begin
        prg_msk = PRG_MASK_128K;
        chr_msk = CHR_MASK_128K;
      end
    endcase
  endfunction

  function automatic void set_banks(input logic [20:0] po, input logic [18:0] pm,
                                    input logic [21:0] co, input logic [17:0] cm);
    prg_off = po;
    prg_msk = pm;
    chr_off = co;
    chr_msk = cm;
  endfunction

  function automatic void refresh_chr_window();
    int unsigned code_eff;
    int unsigned span;
    code_eff = (chr_off != '0 || chr_code != '0) ? chr_code : 4'hF;
    span = (32'hFF >> (~code_eff & 32'hF)) + 1;
    chr_msk = 18'((span << 10) - 1);
  endfunction

  function automatic out_item_t apply_cpu_write(input in_item_t w);
    out_item_t   r;
    logic [15:0] a;
    logic [7:0]  d;
    logic        in_sel, in_en;
    logic [2:0]  c;
    int unsigned k;
    a = w.write_address;
    d = w.write_data;
    in_sel = (a >= 16'h6000) && (a < 16'h8000);
    in_en = (a & EN_DECODE_MASK) == EN_DECODE_ADDR;
    r = '0;
    r.to_core = 1'b1;
    case (board)
      VAR_B37: begin
        if (in_sel) begin
          r.to_core = 1'b0;
          if (sel_en) begin
            k = d[2:0];
            if (k < 3)
              set_banks(21'h0, PRG_MASK_64K, 22'h0, CHR_MASK_128K);
            else if (k == 3)
              set_banks(21'h10000, PRG_MASK_64K, 22'h0, CHR_MASK_128K);
            else if (k < 7)
              set_banks(21'h20000, PRG_MASK_128K, 22'h20000, CHR_MASK_128K);
            else
              set_banks(21'h30000, PRG_MASK_64K, 22'h20000, CHR_MASK_128K);
          end
        end else if (in_en) begin
          r.to_core = 1'b0;
          sel_en = d[7] & ~d[6];
        end
      end
      VAR_B44: begin
        if (in_en) begin
          r.to_core = 1'b0;
          k = d[2:0];
          if (k < 6)
            set_banks(21'(k * 32'h20000), PRG_MASK_128K, 22'(k * 32'h20000),
                      CHR_MASK_128K);
          else
            set_banks(21'hC0000, PRG_MASK_256K, 22'hC0000, CHR_MASK_256K);
        end
      end
      VAR_B45: begin
        if (in_sel && !sel_lock) begin
          r.to_core = 1'b0;
          case (seq_idx)
            2'd0: begin
              chr_off = (chr_off & 22'h3C0000) | ({14'd0, d} << 10);
              refresh_chr_window();
            end
            2'd1: prg_off = {13'd0, d} << 13;
            2'd2: begin
              chr_off = (chr_off & 22'h3FFFF) | ({18'd0, d[7:4]} << 18);
              chr_code = d[3:0];
              refresh_chr_window();
            end
            default: begin
              sel_lock = d[6];
              prg_msk = (({13'd0, ~d[5:0]} + 19'd1) << 13) - 19'd1;
            end
          endcase
          seq_idx = seq_idx + 2'd1;
        end
      end
      VAR_B47, VAR_B49: begin
        if (in_sel) begin
          r.to_core = 1'b0;
          if (sel_en) begin
            if (board == VAR_B47) begin
              k = d[0] ? 32'h20000 : 32'h0;
              prg_off = 21'(k);
              chr_off = 22'(k);
            end else begin
              k = d[7:6] * 32'h20000;
              set_banks(21'(k), PRG_MASK_128K, 22'(k), CHR_MASK_128K);
              bank32 = d[5:4];
              mode32 = d[0];
            end
          end
        end else if (in_en) begin
          r.to_core = 1'b0;
          sel_en = d[7] & ~d[6];
        end
      end
      VAR_B52: begin
        if (in_sel && !sel_lock) begin
          r.to_core = 1'b0;
          if (sel_en) begin
            c = {d[2], d[5:4]};
            if (d[3]) begin
              prg_msk = PRG_MASK_128K;
              prg_off = {1'b0, d[2:0], 17'd0};
            end else begin
              prg_msk = PRG_MASK_256K;
              prg_off = {1'b0, d[2:1], 1'b0, 17'd0};
            end
            if (d[6]) begin
              chr_msk = CHR_MASK_128K;
              chr_off = {2'b0, c, 17'd0};
            end else begin
              chr_msk = CHR_MASK_256K;
              chr_off = {2'b0, c[2:1], 1'b0, 17'd0};
            end
            sel_lock = d[7];
          end
        end else if (in_en) begin
          r.to_core = 1'b0;
          sel_en = d[7] & ~d[6];
        end
      end
      default: begin
        if (in_sel) begin
          r.to_core = 1'b0;
          k = d[1:0];
          if (k < 2)
            set_banks(21'(k * 32'h20000), PRG_MASK_256K, 22'(k * 32'h20000),
                      CHR_MASK_256K);
          else
            set_banks(21'(k * 32'h20000), PRG_MASK_128K, 22'(k * 32'h20000),
                      CHR_MASK_128K);
        end
      end
    endcase
    r.prg_offset = prg_off;
    r.prg_mask = prg_msk;
    r.chr_offset = chr_off;
    r.chr_mask = chr_msk;
    if (board == VAR_B49) begin
      r.prg_mode_mmc3 = mode32;
      r.prg32_base = {2'b0, bank32, 15'd0} | prg_off[18:0];
    end else begin
      r.prg_mode_mmc3 = 1'b1;
      r.prg32_base = '0;
    end
    r.regs_locked = sel_lock;
    return r;
  endfunction

  function automatic int unsigned draw_gap(inout int unsigned run_left, inout bit calm);
    if (run_left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      run_left = $urandom_range(20, 60);
    end
    run_left = run_left - 1;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic in_item_t random_write(input variant_t b);
    in_item_t    w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.write_data = 8'($urandom);
    if (pick < 50) begin
      w.write_address = 16'($urandom_range(16'h6000, 16'h7FFF));
      // keep the lock bits rare so that most of the phase sees open registers
      if (b == VAR_B45 && $urandom_range(0, 31) != 0)
        w.write_data[6] = 1'b0;
      if (b == VAR_B52 && $urandom_range(0, 63) != 0)
        w.write_data[7] = 1'b0;
    end else if (pick < 75) begin
      w.write_address = 16'($urandom);
      w.write_address[15:13] = 3'b101;
      w.write_address[0] = 1'b1;
      if (b != VAR_B44 && $urandom_range(0, 3) != 0)
        w.write_data[7:6] = 2'b10;
    end else begin
      w.write_address = 16'($urandom);
    end
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : bank_predictor
    if (!rst_n) begin
      board = VAR_B37;
      clear_bank_state();
    end else begin
      if (cfg_valid && cfg_ch.ready && cfg_data != VARIANT_LIMIT) begin
        board = variant_t'(cfg_data);
        clear_bank_state();
      end
      if (in_valid && in_ch.ready) begin
        expected_beats.push_back(apply_cpu_write(in_data));
        writes_taken++;
      end
    end
  end

  always @(posedge clk) begin : write_driver
    in_item_t    next_w;
    int unsigned w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!(in_valid && !in_ch.ready)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_writes.size() != 0) begin
        next_w = pending_writes.pop_front();
        w = draw_gap(in_stretch, in_calm);
        in_valid <= 1'b1;
        in_data <= next_w;
        in_gap <= w;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_sink
    int unsigned w;
    if (!rst_n) begin
      out_rdy <= 1'b0;
      out_gap <= 0;
    end else if (long_hold) begin
      out_rdy <= 1'b0;
    end else if (out_ch.valid && out_rdy) begin
      w = draw_gap(out_stretch, out_calm);
      out_gap <= w;
      out_rdy <= (w == 0);
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_rdy <= (out_gap == 1);
    end else begin
      out_rdy <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_ch.valid && out_rdy) begin
      if (expected_beats.size() == 0) begin
        $display("%0t ns: result beat with none expected, actual %h", $time, out_ch.data);
        failures++;
      end else begin
        want = expected_beats.pop_front();
        check_field("to_core", want.to_core, out_ch.data.to_core);
        check_field("prg_offset", want.prg_offset, out_ch.data.prg_offset);
        check_field("prg_mask", want.prg_mask, out_ch.data.prg_mask);
        check_field("chr_offset", want.chr_offset, out_ch.data.chr_offset);
        check_field("chr_mask", want.chr_mask, out_ch.data.chr_mask);
        check_field("prg_mode_mmc3", want.prg_mode_mmc3, out_ch.data.prg_mode_mmc3);
        check_field("prg32_base", want.prg32_base, out_ch.data.prg32_base);
        check_field("regs_locked", want.regs_locked, out_ch.data.regs_locked);
      end
    end
  end

  // Hold the result side off long enough for the input to back up
  initial begin : receiver_hold
    wait (writes_taken >= 300);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (64) @(posedge clk);
    long_hold <= 1'b0;
    wait (writes_taken >= 900);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (80) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic load_write(input logic [15:0] a, input logic [7:0] d);
    in_item_t w;
    w.write_address = a;
    w.write_data = d;
    pending_writes.push_back(w);
    writes_queued++;
  endtask

  task automatic settle();
    while (writes_taken != writes_queued || expected_beats.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_board(input cfg_item_t code);
    settle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= code;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input cfg_item_t code, input int unsigned n);
    variant_t gen_board;
    write_board(code);
    gen_board = (code == VARIANT_LIMIT) ? board : variant_t'(code);
    repeat (n) begin
      pending_writes.push_back(random_write(gen_board));
      writes_queued++;
    end
  endtask

  cfg_item_t phase_codes[14] = '{VAR_B205, VAR_B44, VAR_B47, VAR_B37, VAR_B45, VAR_B52,
                                 VAR_B49, VARIANT_LIMIT, VAR_B45, VAR_B52, VAR_B37,
                                 VAR_B205, VARIANT_LIMIT, VAR_B49};

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // board 37 straight out of reset: select while disabled, enable, select twice, disable
    load_write(16'h6000, 8'h07);
    load_write(16'hA001, 8'h80);
    load_write(16'h7FFF, 8'h03);
    load_write(16'h6000, 8'h07);
    load_write(16'hBFFF, 8'hC0);
    load_write(16'h0000, 8'hFF);
    load_write(16'h8000, 8'h00);

    // unused board code leaves the state alone
    write_board(VARIANT_LIMIT);
    load_write(16'h6000, 8'h04);

    // board 45: zero CHR offset and mask code, full sequence, then locked
    write_board(VAR_B45);
    load_write(16'h6000, 8'h00);
    load_write(16'h6001, 8'hFF);
    load_write(16'h7000, 8'h0F);
    load_write(16'h7FFF, 8'h40);
    load_write(16'h6000, 8'h12);

    write_board(VAR_B49);
    load_write(16'hA001, 8'h80);
    load_write(16'h6000, 8'hF1);
    load_write(16'h6000, 8'h00);

    write_board(VAR_B52);
    load_write(16'hA001, 8'h80);
    load_write(16'h6000, 8'h7F);
    load_write(16'h6000, 8'h80);
    load_write(16'h6000, 8'h00);

    foreach (phase_codes[i])
      random_phase(phase_codes[i], 95);

    settle();
    repeat (4) @(posedge clk);
    if (failures == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mobr_pkg.sv
rtl/mobr_chan_if.sv
rtl/mobr_update.sv
rtl/multicart_outer_bank_registers_top.sv
dv/multicart_outer_bank_registers_top_tb.sv
